@@ hw/rtl/fpba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // default sizing
    localparam int BLOCKS_DEF    = 16;
    localparam int SIZE_BITS_DEF = 16;

    // fixed field widths
    localparam int IDX_FIELD_W   = 4;
    localparam int AMT_FIELD_W   = 16;
    localparam int POLICY_W      = 2;
    localparam int COUNT_W       = 5;

    // stream payload widths (padded to whole bytes)
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 24;

    // configuration port
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    // placement rules
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // item kinds
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/fit_policy_block_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                        | content
//  ---------+-----+--------------------------------+---------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser | load or allocation request
//  m_*      | out | m_tvalid m_tready m_tdata m_tuser | found, block, size left
//  cfg_*    | in  | cfg_we cfg_index cfg_data      | policy, block_count
//
//  A load goes through the result register to the output register. A request
//  scans the table through the single RAM read port, one entry per cycle, up
//  to limit = min(block_count, BLOCKS); first fit stops at the first hit.
//  s_tready is high only while the sequencer is idle. The result register
//  holds one finished transaction; a stalled m_tready holds the sequencer in
//  its response state. Reset clears control state and the config registers;
//  the block table has no reset and must be loaded before it is searched.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit #(
    parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fpba_pkg::IN_DATA_W-1:0]  s_tdata,  // block_index[3:0], amount[19:4]
    input  wire logic                            s_tuser,  // mode
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [fpba_pkg::OUT_DATA_W-1:0] m_tdata,  // chosen_block[3:0], left_after[19:4]
    output logic                                 m_tuser,  // found
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fpba_pkg::*;

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > AMT_FIELD_W) ? SIZE_BITS : AMT_FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESP
    } state_t;

    // input unpack
    logic                   in_mode;
    logic [IDX_FIELD_W-1:0] in_idx;
    logic [AMT_FIELD_W-1:0] in_amount;
    logic                   s_fire;

    assign in_mode   = s_tuser;
    assign in_idx    = s_tdata[IDX_FIELD_W-1:0];
    assign in_amount = s_tdata[IDX_FIELD_W +: AMT_FIELD_W];

    // registers
    state_t                 state_reg, state_next;
    logic [POLICY_W-1:0]    policy_reg;
    logic [COUNT_W-1:0]     block_count_reg;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   have_reg, have_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]   best_val_reg, best_val_next;
    logic [AMT_FIELD_W-1:0] amount_reg, amount_next;
    logic                   res_found_reg, res_found_next;
    logic [IDX_FIELD_W-1:0] res_idx_reg, res_idx_next;
    logic [AMT_FIELD_W-1:0] res_left_reg, res_left_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_found_reg, m_found_next;
    logic [IDX_FIELD_W-1:0] m_idx_reg, m_idx_next;
    logic [AMT_FIELD_W-1:0] m_left_reg, m_left_next;

    // RAM ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (BLOCKS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare / subtract datapath
    logic [CMP_W-1:0]     cand_w;
    logic [CMP_W-1:0]     amt_w;
    logic                 fits;
    logic                 better;
    logic [CMP_W-1:0]     diff_w;
    logic [SIZE_BITS-1:0] load_val;
    logic                 load_ok;
    logic [CNT_W-1:0]     req_limit;
    logic [CMP_W-1:0]     load_w;

    assign cand_w   = CMP_W'(ram_rdata);
    assign amt_w    = CMP_W'(amount_reg);
    assign fits     = (cand_w >= amt_w);
    assign diff_w   = CMP_W'(best_val_reg) - amt_w;
    assign load_val = SIZE_BITS'(in_amount);
    assign load_w   = CMP_W'(load_val);
    assign load_ok  = (32'(in_idx) < 32'(BLOCKS));
    assign req_limit = (32'(block_count_reg) > 32'(BLOCKS)) ? CNT_W'(BLOCKS)
                                                            : CNT_W'(block_count_reg);

    always_comb
    begin
        unique case (policy_reg)
            POLICY_BEST:  better = (ram_rdata < best_val_reg);
            POLICY_WORST: better = (ram_rdata > best_val_reg);
            default:      better = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        amount_next    = amount_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_left_next  = res_left_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        m_left_next    = m_left_reg;
        ram_we         = 1'b0;
        ram_waddr      = best_idx_reg;
        ram_wdata      = SIZE_BITS'(diff_w);
        ram_re         = 1'b0;
        ram_raddr      = issue_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    amount_next = in_amount;
                    if (in_mode == MODE_LOAD)
                    begin
                        ram_we    = load_ok;
                        ram_waddr = IDX_W'(in_idx);
                        ram_wdata = load_val;
                        res_found_next = load_ok;
                        res_idx_next   = load_ok ? in_idx : '0;
                        res_left_next  = load_ok ? load_w[AMT_FIELD_W-1:0] : '0;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        limit_next = req_limit;
                        issue_next = '0;
                        have_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, compare the entry read last cycle
                if (issue_reg < limit_reg)
                begin
                    ram_re         = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg && fits && (!have_reg || better))
                begin
                    have_next     = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_val_next = ram_rdata;
                end
                if (cmp_valid_reg && fits && policy_reg != POLICY_BEST
                    && policy_reg != POLICY_WORST)
                begin
                    // first fit: stop at the first hit
                    cmp_valid_next = 1'b0;
                    state_next     = S_WRITE;
                end
                else if (!cmp_valid_reg && !(issue_reg < limit_reg))
                begin
                    if (have_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        res_found_next = 1'b0;
                        res_idx_next   = '0;
                        res_left_next  = '0;
                        state_next     = S_RESP;
                    end
                end
            end

            S_WRITE:
            begin
                ram_we         = 1'b1;
                res_found_next = 1'b1;
                res_idx_next   = IDX_FIELD_W'(best_idx_reg);
                res_left_next  = AMT_FIELD_W'(CMP_W'(SIZE_BITS'(diff_w)));
                state_next     = S_RESP;
            end

            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_idx_next    = res_idx_reg;
                    m_left_next   = res_left_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            policy_reg      <= POLICY_FIRST;
            block_count_reg <= COUNT_W'(16);
            limit_reg       <= '0;
            issue_reg       <= '0;
            cmp_valid_reg   <= 1'b0;
            have_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            have_reg      <= have_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POLICY:      policy_reg      <= cfg_data[POLICY_W-1:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_val_reg  <= best_val_next;
        amount_reg    <= amount_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_left_reg  <= res_left_next;
        m_found_reg   <= m_found_next;
        m_idx_reg     <= m_idx_next;
        m_left_reg    <= m_left_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {(OUT_DATA_W - IDX_FIELD_W - AMT_FIELD_W)'(0), m_left_reg, m_idx_reg};

endmodule
`default_nettype wire

@@ hw/rtl/fpba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
